[src/rcfr_pkg.sv]
package rcfr_pkg;

    localparam int CHAN_BITS    = 11;
    localparam int NUM_CHANNELS = 16;
    localparam int MIN_PAYLOAD  = 22;
    localparam int ACC_W        = CHAN_BITS + 8;
    localparam int CNT_W        = 5;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    localparam logic [7:0] CRC_POLY = 8'hD5;

    // Registers sit at byte addresses 0 and 4, so bit 2 of the address picks one.
    localparam logic REG_ACCEPTED_TYPE = 1'b0;
    localparam logic REG_MAX_LENGTH    = 1'b1;

    localparam logic [7:0] ACCEPTED_TYPE_RESET = 8'd22;
    localparam logic [5:0] MAX_LENGTH_RESET    = 6'd62;

    typedef struct packed {
        logic [7:0] accepted_type;
        logic [5:0] max_length;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[src/rcfr_regs.sv]
module rcfr_regs
    import rcfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_ACCEPTED_TYPE: cfg_next.accepted_type = pwdata[7:0];
                REG_MAX_LENGTH:    cfg_next.max_length    = pwdata[5:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ACCEPTED_TYPE: prdata = {24'd0, cfg_reg.accepted_type};
            REG_MAX_LENGTH:    prdata = {26'd0, cfg_reg.max_length};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accepted_type <= ACCEPTED_TYPE_RESET;
            cfg_reg.max_length    <= MAX_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/rc_link_frame_receiver_top.sv]
// Channel   Handshake            Transaction
// in        in_valid/in_ready    command, rx_byte, idle_gap: one received byte or line error
// out       out_valid/out_ready  channel_index, channel_value, last_channel
// apb       psel/penable/pready  register write or read
//
// Each byte taken is written to the frame store; from the type byte on the CRC is updated too.
// A good channel frame then unpacks from the store through its single read port: each payload
// byte is read into an accumulator and each channel is emitted from it, while in_ready is low.
// After reset the framing counters are clear; the frame store holds no reset value.
// A stalled output holds the unpacker in its emit step; input is never dropped.
module rc_link_frame_receiver_top
    import rcfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64,
    parameter int MIN_FRAME_BYTES = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    command,
    input  logic [7:0]              rx_byte,
    input  logic                    idle_gap,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [3:0]              channel_index,
    output logic [CHAN_BITS-1:0]    channel_value,
    output logic                    last_channel
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int DECODE_MIN_TOTAL = MIN_PAYLOAD + 4;
    localparam int FIRST_CHAN_BYTE  = 3;

    cfg_t cfg;

    rcfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [7:0] mem [MAX_FRAME_BYTES];
    logic [7:0] mem_rd_data_reg;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          bc_reg, bc_next;
    logic [CW-1:0]          exp_reg, exp_next;
    logic [7:0]             crc_reg, crc_next;
    logic [7:0]             type_reg, type_next;
    logic [AW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [3:0]             ch_reg, ch_next;
    logic                   out_valid_reg, out_valid_next;
    logic [3:0]             out_index_reg;
    logic [CHAN_BITS-1:0]   out_value_reg;
    logic                   out_last_reg;

    logic                   in_fire;
    logic                   byte_fire;
    logic                   restart;
    logic [CW-1:0]          bc_eff;
    logic [CW-1:0]          exp_eff;
    logic [CW-1:0]          bc_inc;
    logic [8:0]             len_total;
    logic                   frame_ok;
    logic                   mem_re;
    logic                   emit;
    logic [CNT_W-1:0]       cnt_after_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign byte_fire = in_fire && !command;

    assign restart   = idle_gap || (bc_reg >= CW'(MAX_FRAME_BYTES));
    assign bc_eff    = restart ? '0 : bc_reg;
    assign exp_eff   = restart ? '0 : exp_reg;
    assign bc_inc    = bc_eff + 1'b1;
    assign len_total = {1'b0, rx_byte} + 9'd2;

    // On the closing byte the running CRC covers the type byte and the payload.
    assign frame_ok = (crc_reg == rx_byte) && (type_reg == cfg.accepted_type)
                      && (exp_eff >= CW'(DECODE_MIN_TOTAL));

    assign mem_re         = (state_reg == ST_READ);
    assign emit           = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign cnt_after_load = cnt_reg + CNT_W'(8);

    always_comb
    begin
        state_next     = state_reg;
        bc_next        = bc_reg;
        exp_next       = exp_reg;
        crc_next       = crc_reg;
        type_next      = type_reg;
        rd_ptr_next    = rd_ptr_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && command)
                begin
                    bc_next  = '0;
                    exp_next = '0;
                end
                else if (byte_fire)
                begin
                    if (bc_eff >= CW'(2))
                    begin
                        crc_next = crc8_step((bc_eff == CW'(2)) ? 8'd0 : crc_reg, rx_byte);
                    end
                    if (bc_eff == CW'(2))
                    begin
                        type_next = rx_byte;
                    end

                    if (bc_inc == CW'(2))
                    begin
                        if (rx_byte < 8'd2 || rx_byte > {2'b00, cfg.max_length}
                            || len_total < 9'(MIN_FRAME_BYTES)
                            || len_total > 9'(MAX_FRAME_BYTES))
                        begin
                            bc_next  = '0;
                            exp_next = '0;
                        end
                        else
                        begin
                            bc_next  = bc_inc;
                            exp_next = len_total[CW-1:0];
                        end
                    end
                    else if (exp_eff != '0 && bc_inc == exp_eff)
                    begin
                        bc_next  = '0;
                        exp_next = '0;
                        if (frame_ok)
                        begin
                            state_next  = ST_READ;
                            rd_ptr_next = AW'(FIRST_CHAN_BYTE);
                            acc_next    = '0;
                            cnt_next    = '0;
                            ch_next     = '0;
                        end
                    end
                    else
                    begin
                        bc_next  = bc_inc;
                        exp_next = exp_eff;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                acc_next    = acc_reg | (ACC_W'(mem_rd_data_reg) << cnt_reg);
                cnt_next    = cnt_after_load;
                rd_ptr_next = rd_ptr_reg + 1'b1;
                state_next  = (cnt_after_load >= CNT_W'(CHAN_BITS)) ? ST_EMIT : ST_READ;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    acc_next       = acc_reg >> CHAN_BITS;
                    cnt_next       = cnt_reg - CNT_W'(CHAN_BITS);
                    ch_next        = ch_reg + 1'b1;
                    // At most seven bits remain after a channel, so another byte is always due.
                    state_next     = (ch_reg == 4'(NUM_CHANNELS - 1)) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Input is held off while unpacking, so the store never sees a read and a write together.
    always_ff @(posedge clk)
    begin
        if (byte_fire)
        begin
            mem[bc_eff[AW-1:0]] <= rx_byte;
        end
        if (mem_re)
        begin
            mem_rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_index_reg <= ch_reg;
            out_value_reg <= acc_reg[CHAN_BITS-1:0];
            out_last_reg  <= (ch_reg == 4'(NUM_CHANNELS - 1));
        end
        crc_reg    <= crc_next;
        type_reg   <= type_next;
        rd_ptr_reg <= rd_ptr_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bc_reg        <= '0;
            exp_reg       <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bc_reg        <= bc_next;
            exp_reg       <= exp_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_index = out_index_reg;
    assign channel_value = out_value_reg;
    assign last_channel  = out_last_reg;

endmodule

[src/rcfr_checker.sv]
module rcfr_checker
    import rcfr_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pready,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [3:0]           channel_index,
    input logic [CHAN_BITS-1:0] channel_value,
    input logic                 last_channel
);

    // A stalled channel transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(channel_index)
            && $stable(channel_value) && $stable(last_channel))
        else $error("output payload changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_channel == (channel_index == 4'(NUM_CHANNELS - 1))))
        else $error("last_channel does not match channel_index");

    // While a frame is still being unpacked, no new byte may enter.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_channel |-> !in_ready)
        else $error("input accepted during frame unpacking");

    // The last channel may be loaded in the same cycle as the one before it leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_channel |=> out_valid || !in_ready)
        else $error("unpacking ended before the last channel");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind rc_link_frame_receiver_top rcfr_checker u_rcfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pready        (pready),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel)
);

[dv/tb_rc_link_frame_receiver_top.sv]
`timescale 1ns / 1ps

module tb_rc_link_frame_receiver_top;
    import rcfr_pkg::*;

    localparam int FRAME_BYTES_MAX = 64;
    localparam int FRAME_BYTES_MIN = 4;
    localparam int SETTLE_CYCLES   = 100;
    localparam int RANDOM_ITEMS    = 55;

    localparam logic [ADDR_W-1:0] ADDR_ACCEPTED_TYPE = {REG_ACCEPTED_TYPE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_MAX_LENGTH    = {REG_MAX_LENGTH, 2'b00};

    localparam logic CMD_BYTE       = 1'b0;
    localparam logic CMD_LINE_ERROR = 1'b1;

    localparam int PAY_RANDOM = 0;
    localparam int PAY_SPLIT  = 1;

    typedef struct {
        logic [3:0]           idx;
        logic [CHAN_BITS-1:0] value;
        logic                 last;
    } channel_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_ready;
    logic                 command;
    logic [7:0]           rx_byte;
    logic                 idle_gap;
    logic                 out_valid;
    logic                 out_ready;
    logic [3:0]           channel_index;
    logic [CHAN_BITS-1:0] channel_value;
    logic                 last_channel;

    // Receiver model state and its copy of the registers.
    logic [7:0] rx_store [0:FRAME_BYTES_MAX-1];
    logic [6:0] rx_count    = '0;
    logic [6:0] frame_total = '0;
    logic [7:0] cfg_type    = ACCEPTED_TYPE_RESET;
    logic [5:0] cfg_max     = MAX_LENGTH_RESET;

    channel_t chan_expect_q [$];
    int       error_count = 0;
    bit       in_gaps     = 1'b1;
    bit       out_stalls  = 1'b1;

    rc_link_frame_receiver_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .rx_byte       (rx_byte),
        .idle_gap      (idle_gap),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last_channel  (last_channel)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [7:0] crc8_d5(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc ^ data;
        repeat (8)
        begin
            r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // Advances the receiver model by one accepted transaction and queues any channels it yields.
    function automatic void predict_item(input logic cmd, input logic [7:0] b, input logic idl);
        int         lf;
        int         total;
        int         bitpos;
        int         base;
        int         k;
        logic [7:0] crc;
        logic [23:0] window;
        channel_t   ch;
        if (cmd == CMD_LINE_ERROR)
        begin
            rx_count    = '0;
            frame_total = '0;
            return;
        end
        if (idl || rx_count >= FRAME_BYTES_MAX)
        begin
            rx_count    = '0;
            frame_total = '0;
        end
        rx_store[rx_count] = b;
        rx_count = rx_count + 7'd1;
        if (rx_count == 7'd2)
        begin
            lf    = rx_store[1];
            total = lf + 2;
            if (lf < 2 || lf > cfg_max || total < FRAME_BYTES_MIN || total > FRAME_BYTES_MAX)
            begin
                rx_count    = '0;
                frame_total = '0;
            end
            else
            begin
                frame_total = 7'(total);
            end
            return;
        end
        if (frame_total != '0 && rx_count == frame_total)
        begin
            total = frame_total;
            lf    = rx_store[1];
            crc   = 8'h00;
            for (k = 2; k < total - 1; k++)
            begin
                crc = crc8_d5(crc, rx_store[k]);
            end
            if (crc == rx_store[total-1] && rx_store[2] == cfg_type && lf - 2 >= MIN_PAYLOAD)
            begin
                for (k = 0; k < NUM_CHANNELS; k++)
                begin
                    bitpos   = CHAN_BITS * k;
                    base     = 3 + bitpos / 8;
                    window   = {rx_store[base+2], rx_store[base+1], rx_store[base]};
                    window   = window >> (bitpos % 8);
                    ch.idx   = 4'(k);
                    ch.value = window[CHAN_BITS-1:0];
                    ch.last  = (k == NUM_CHANNELS - 1);
                    chan_expect_q.push_back(ch);
                end
            end
            rx_count    = '0;
            frame_total = '0;
        end
    endfunction

    always @(posedge clk)
    begin : check_channels
        channel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (chan_expect_q.size() == 0)
            begin
                $error("unexpected channel transaction: channel_index %0d channel_value %0d",
                       channel_index, channel_value);
                error_count++;
            end
            else
            begin
                want = chan_expect_q.pop_front();
                if (channel_index !== want.idx)
                begin
                    $error("channel_index: expected %0d, actual %0d", want.idx, channel_index);
                    error_count++;
                end
                if (channel_value !== want.value)
                begin
                    $error("channel_value: expected %0d, actual %0d", want.value, channel_value);
                    error_count++;
                end
                if (last_channel !== want.last)
                begin
                    $error("last_channel: expected %0d, actual %0d", want.last, last_channel);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_stalls && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] b, input logic idl);
        if (in_gaps && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        rx_byte  <= b;
        idle_gap <= idl;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(cmd, b, idl);
    endtask

    // Builds a frame of length byte lf and sends its first `count` bytes.
    task automatic send_frame(input logic [7:0] ftype, input int lf, input int count,
                              input logic lead_idle, input int fill, input logic bad_crc);
        logic [7:0] fb [0:127];
        logic [7:0] crc;
        int         k;
        fb[0] = 8'($urandom_range(0, 255));
        fb[1] = 8'(lf);
        fb[2] = ftype;
        for (k = 3; k <= lf; k++)
        begin
            if (fill == PAY_SPLIT)
                fb[k] = (k - 3 < 11) ? 8'h00 : 8'hFF;
            else if ($urandom_range(0, 7) == 0)
                fb[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                fb[k] = 8'($urandom_range(0, 255));
        end
        crc = 8'h00;
        for (k = 2; k <= lf; k++)
        begin
            crc = crc8_d5(crc, fb[k]);
        end
        fb[lf+1] = bad_crc ? (crc ^ 8'($urandom_range(1, 255))) : crc;
        for (k = 0; k < count; k++)
        begin
            send_item(CMD_BYTE, fb[k], (k == 0) ? lead_idle : 1'b0);
        end
    endtask

    // Mostly channel frames of modest size; now and then any length byte from 2 to 63.
    function automatic int pick_length();
        int top;
        top = (cfg_max > 62) ? 62 : cfg_max;
        if (top >= 24 && $urandom_range(0, 4) != 0)
        begin
            if ($urandom_range(0, 3) != 0)
                return $urandom_range(24, (top < 30) ? top : 30);
            return $urandom_range(24, top);
        end
        return $urandom_range(2, 63);
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (chan_expect_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] wdata,
                                output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [ADDR_W-1:0] addr, input logic [7:0] want);
        logic [DATA_W-1:0] rdata;
        apb_transfer(1'b0, addr, '0, rdata);
        if (addr == ADDR_ACCEPTED_TYPE && rdata[7:0] !== want)
        begin
            $error("accepted_frame_type: expected %0d, actual %0d", want, rdata[7:0]);
            error_count++;
        end
        if (addr == ADDR_MAX_LENGTH && rdata[5:0] !== want[5:0])
        begin
            $error("max_length_field: expected %0d, actual %0d", want[5:0], rdata[5:0]);
            error_count++;
        end
    endtask

    task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [7:0] value);
        logic [DATA_W-1:0] rdata;
        wait_drained();
        apb_transfer(1'b1, addr, DATA_W'(value), rdata);
        if (addr == ADDR_ACCEPTED_TYPE)
            cfg_type = value;
        else
            cfg_max = value[5:0];
        check_register(addr, value);
    endtask

    task automatic test_register_reset();
        check_register(ADDR_ACCEPTED_TYPE, ACCEPTED_TYPE_RESET);
        check_register(ADDR_MAX_LENGTH, {2'b00, MAX_LENGTH_RESET});
    endtask

    task automatic test_directed_frames();
        // A partial frame cut off by a line error; the short frame after it must start fresh.
        send_frame(cfg_type, 24, 3, 1'b1, PAY_RANDOM, 1'b0);
        send_item(CMD_LINE_ERROR, 8'hFF, 1'b1);
        send_frame(cfg_type, 2, 4, 1'b0, PAY_RANDOM, 1'b0);
        // A partial frame abandoned at an idle gap, then channels at both extremes.
        send_frame(cfg_type, 30, 5, 1'b1, PAY_RANDOM, 1'b0);
        send_frame(cfg_type, 24, 26, 1'b1, PAY_SPLIT, 1'b0);
        // Length bytes below two and one above the limit.
        send_item(CMD_BYTE, 8'hC8, 1'b1);
        send_item(CMD_BYTE, 8'h00, 1'b0);
        send_item(CMD_BYTE, 8'hC8, 1'b1);
        send_item(CMD_BYTE, 8'h01, 1'b0);
        send_item(CMD_BYTE, 8'hC8, 1'b1);
        send_item(CMD_BYTE, 8'd63, 1'b0);
        send_frame(cfg_type, 24, 26, 1'b1, PAY_RANDOM, 1'b0);
    endtask

    task automatic test_config_settings();
        logic [7:0] type_set [0:5];
        logic [7:0] max_set  [0:5];
        int         k;
        int         lf;
        type_set[0] = 8'd0;
        max_set[0]  = 8'd24;
        type_set[1] = 8'd255;
        max_set[1]  = 8'd2;
        type_set[2] = 8'($urandom_range(0, 255));
        max_set[2]  = 8'd1;
        type_set[3] = 8'($urandom_range(0, 255));
        max_set[3]  = 8'd63;
        type_set[4] = 8'($urandom_range(0, 255));
        max_set[4]  = 8'($urandom_range(24, 62));
        type_set[5] = ACCEPTED_TYPE_RESET;
        max_set[5]  = {2'b00, MAX_LENGTH_RESET};
        for (k = 0; k < 6; k++)
        begin
            write_register(ADDR_ACCEPTED_TYPE, type_set[k]);
            write_register(ADDR_MAX_LENGTH, max_set[k]);
            // A channel frame where the length limit allows one, else the shortest frame.
            lf = (cfg_max >= 6'd24) ? 24 : 2;
            send_frame(cfg_type, lf, lf + 2, 1'b1, PAY_RANDOM, 1'b0);
            // A length byte of 63 passes a limit of 63 but overruns the frame store.
            if (cfg_max == 6'd63)
            begin
                send_frame(cfg_type, 63, 6, 1'b1, PAY_RANDOM, 1'b0);
            end
        end
    endtask

    task automatic test_random_traffic();
        int sent;
        int pick;
        int lf;
        int n;
        int k;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            in_gaps    = ($urandom_range(0, 3) != 0);
            out_stalls = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            lf   = pick_length();
            if (pick < 65)
            begin
                send_frame(cfg_type, lf, lf + 2, $urandom_range(0, 3) != 0, PAY_RANDOM, 1'b0);
                sent += lf + 2;
            end
            else if (pick < 72)
            begin
                send_frame(cfg_type, lf, lf + 2, 1'b1, PAY_RANDOM, 1'b1);
                sent += lf + 2;
            end
            else if (pick < 79)
            begin
                send_frame(cfg_type ^ 8'($urandom_range(1, 255)), lf, lf + 2, 1'b1,
                           PAY_RANDOM, 1'b0);
                sent += lf + 2;
            end
            else if (pick < 86)
            begin
                n = $urandom_range(1, lf + 1);
                send_frame(cfg_type, lf, n, 1'b1, PAY_RANDOM, 1'b0);
                sent += n;
            end
            else if (pick < 92)
            begin
                send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b1);
                case ($urandom_range(0, 2))
                    0: send_item(CMD_BYTE, 8'h00, 1'b0);
                    1: send_item(CMD_BYTE, 8'h01, 1'b0);
                    default: send_item(CMD_BYTE, 8'($urandom_range(cfg_max + 1, 255)), 1'b0);
                endcase
                sent += 2;
            end
            else if (pick < 96)
            begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                begin
                    send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                sent += n;
            end
            else
            begin
                send_item(CMD_LINE_ERROR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent += 1;
            end
        end
    endtask

    task automatic test_back_to_back();
        int k;
        int lf;
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
        for (k = 0; k < 2; k++)
        begin
            lf = $urandom_range(24, 30);
            send_frame(cfg_type, lf, lf + 2, 1'b1, PAY_RANDOM, 1'b0);
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        command  <= CMD_BYTE;
        rx_byte  <= 8'h00;
        idle_gap <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_directed_frames();
        test_config_settings();
        test_random_traffic();
        test_back_to_back();

        wait_drained();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
src/rcfr_pkg.sv
src/rcfr_regs.sv
src/rc_link_frame_receiver_top.sv
src/rcfr_checker.sv
dv/tb_rc_link_frame_receiver_top.sv
